// ===== hw/rtl/abv_pkg.sv =====
`timescale 1ns / 1ps

package abv_pkg;

    // Input beat: one material point.
    typedef struct packed {
        logic signed [31:0] mean_stress;
        logic signed [31:0] volume_change;
        logic [30:0]        time_step;
        logic [30:0]        point_volume;
        logic [30:0]        point_density;
        logic [30:0]        sound_speed_in;
    } abv_in_t;

    // Result beat: viscosity, sound speed and the compression flag.
    typedef struct packed {
        logic signed [31:0] bulk_viscosity;
        logic [30:0]        sound_speed_out;
        logic               compressing;
    } abv_out_t;

    // Register map.
    localparam int         ADDR_BITS = 4;
    localparam logic [1:0] REG_QUAD  = 2'd0;
    localparam logic [1:0] REG_LIN   = 2'd1;
    localparam logic [1:0] REG_TINY  = 2'd2;

    // Register reset values.
    localparam logic [19:0] QUAD_RESET = 20'd98304;
    localparam logic [19:0] LIN_RESET  = 20'd3932;
    localparam logic [15:0] TINY_RESET = 16'd1;

endpackage

// ===== hw/rtl/abv_div.sv =====
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per pipeline stage.
module abv_div #(
    parameter int NW = 48,
    parameter int DW = 32,
    parameter int SW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_vld,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    input  logic [SW-1:0] in_side,
    output logic          out_vld,
    output logic [NW-1:0] out_quo,
    output logic [SW-1:0] out_side
);

    logic          vld_reg  [NW];
    logic [NW-1:0] num_reg  [NW];
    logic [DW-1:0] den_reg  [NW];
    logic [DW-1:0] rem_reg  [NW];
    logic [NW-1:0] quo_reg  [NW];
    logic [SW-1:0] side_reg [NW];

    genvar i;
    for (i = 0; i < NW; i++) begin : g_stage
        logic          vld_i;
        logic [NW-1:0] num_i;
        logic [DW-1:0] den_i;
        logic [DW-1:0] rem_i;
        logic [NW-1:0] quo_i;
        logic [SW-1:0] side_i;
        logic [DW:0]   trial;
        logic          take;

        if (i == 0) begin : g_first
            assign vld_i  = in_vld;
            assign num_i  = in_num;
            assign den_i  = in_den;
            assign rem_i  = '0;
            assign quo_i  = '0;
            assign side_i = in_side;
        end else begin : g_next
            assign vld_i  = vld_reg[i-1];
            assign num_i  = num_reg[i-1];
            assign den_i  = den_reg[i-1];
            assign rem_i  = rem_reg[i-1];
            assign quo_i  = quo_reg[i-1];
            assign side_i = side_reg[i-1];
        end

        // Shift in the next numerator bit and try the subtraction.
        always_comb
        begin
            trial = {rem_i, num_i[NW-1-i]};
            take  = (trial >= {1'b0, den_i});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else
            begin
                vld_reg[i] <= vld_i;
            end
        end

        always_ff @(posedge clk)
        begin
            num_reg[i]  <= num_i;
            den_reg[i]  <= den_i;
            side_reg[i] <= side_i;
            rem_reg[i]  <= take ? DW'(trial - {1'b0, den_i}) : trial[DW-1:0];
            quo_reg[i]  <= quo_i | (take ? (NW'(1) << (NW-1-i)) : NW'(0));
        end
    end

    assign out_vld  = vld_reg[NW-1];
    assign out_quo  = quo_reg[NW-1];
    assign out_side = side_reg[NW-1];

endmodule

// ===== hw/rtl/abv_cbrt.sv =====
`timescale 1ns / 1ps

// Floor cube root, one root bit per pipeline stage. The running cube and
// square are kept so that each stage needs only shifts and adds.
module abv_cbrt #(
    parameter int TW = 63,
    parameter int SW = 8,
    parameter int RB = (TW + 2) / 3
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_vld,
    input  logic [TW-1:0] in_t,
    input  logic [SW-1:0] in_side,
    output logic          out_vld,
    output logic [RB-1:0] out_root,
    output logic [SW-1:0] out_side
);

    localparam int XW = 3 * RB + 2;

    logic            vld_reg  [RB];
    logic [TW-1:0]   t_reg    [RB];
    logic [RB-1:0]   r_reg    [RB];
    logic [2*RB-1:0] r2_reg   [RB];
    logic [XW-1:0]   y_reg    [RB];
    logic [SW-1:0]   side_reg [RB];

    genvar j;
    for (j = 0; j < RB; j++) begin : g_stage
        localparam int B = RB - 1 - j;
        logic            vld_i;
        logic [TW-1:0]   t_i;
        logic [RB-1:0]   r_i;
        logic [2*RB-1:0] r2_i;
        logic [XW-1:0]   y_i;
        logic [SW-1:0]   side_i;
        logic [XW-1:0]   r2x;
        logic [XW-1:0]   rx;
        logic [XW-1:0]   trial;
        logic            take;

        if (j == 0) begin : g_first
            assign vld_i  = in_vld;
            assign t_i    = in_t;
            assign r_i    = '0;
            assign r2_i   = '0;
            assign y_i    = '0;
            assign side_i = in_side;
        end else begin : g_next
            assign vld_i  = vld_reg[j-1];
            assign t_i    = t_reg[j-1];
            assign r_i    = r_reg[j-1];
            assign r2_i   = r2_reg[j-1];
            assign y_i    = y_reg[j-1];
            assign side_i = side_reg[j-1];
        end

        // (r + 2^B)^3 = r^3 + 3 r^2 2^B + 3 r 2^2B + 2^3B
        always_comb
        begin
            r2x   = XW'(r2_i);
            rx    = XW'(r_i);
            trial = y_i + (((r2x << 1) + r2x) << B) + (((rx << 1) + rx) << (2 * B))
                  + (XW'(1) << (3 * B));
            take  = (trial <= XW'(t_i));
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else
            begin
                vld_reg[j] <= vld_i;
            end
        end

        always_ff @(posedge clk)
        begin
            t_reg[j]    <= t_i;
            side_reg[j] <= side_i;
            if (take)
            begin
                y_reg[j]  <= trial;
                r_reg[j]  <= r_i | (RB'(1) << B);
                r2_reg[j] <= r2_i + ((2*RB)'(r_i) << (B + 1)) + ((2*RB)'(1) << (2 * B));
            end
            else
            begin
                y_reg[j]  <= y_i;
                r_reg[j]  <= r_i;
                r2_reg[j] <= r2_i;
            end
        end
    end

    assign out_vld  = vld_reg[RB-1];
    assign out_root = r_reg[RB-1];
    assign out_side = side_reg[RB-1];

endmodule

// ===== hw/rtl/abv_sqrt.sv =====
`timescale 1ns / 1ps

// Floor square root, one root bit per pipeline stage.
module abv_sqrt #(
    parameter int RB = 32,
    parameter int SW = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_vld,
    input  logic [2*RB-1:0] in_t,
    input  logic [SW-1:0]   in_side,
    output logic            out_vld,
    output logic [RB-1:0]   out_root,
    output logic [SW-1:0]   out_side
);

    localparam int XW = 2 * RB + 1;

    logic            vld_reg  [RB];
    logic [2*RB-1:0] t_reg    [RB];
    logic [RB-1:0]   r_reg    [RB];
    logic [XW-1:0]   y_reg    [RB];
    logic [SW-1:0]   side_reg [RB];

    genvar j;
    for (j = 0; j < RB; j++) begin : g_stage
        localparam int B = RB - 1 - j;
        logic            vld_i;
        logic [2*RB-1:0] t_i;
        logic [RB-1:0]   r_i;
        logic [XW-1:0]   y_i;
        logic [SW-1:0]   side_i;
        logic [XW-1:0]   trial;
        logic            take;

        if (j == 0) begin : g_first
            assign vld_i  = in_vld;
            assign t_i    = in_t;
            assign r_i    = '0;
            assign y_i    = '0;
            assign side_i = in_side;
        end else begin : g_next
            assign vld_i  = vld_reg[j-1];
            assign t_i    = t_reg[j-1];
            assign r_i    = r_reg[j-1];
            assign y_i    = y_reg[j-1];
            assign side_i = side_reg[j-1];
        end

        // (r + 2^B)^2 = r^2 + r 2^(B+1) + 2^2B
        always_comb
        begin
            trial = y_i + (XW'(r_i) << (B + 1)) + (XW'(1) << (2 * B));
            take  = (trial <= XW'(t_i));
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else
            begin
                vld_reg[j] <= vld_i;
            end
        end

        always_ff @(posedge clk)
        begin
            t_reg[j]    <= t_i;
            side_reg[j] <= side_i;
            y_reg[j]    <= take ? trial : y_i;
            r_reg[j]    <= take ? (r_i | (RB'(1) << B)) : r_i;
        end
    end

    assign out_vld  = vld_reg[RB-1];
    assign out_root = r_reg[RB-1];
    assign out_side = side_reg[RB-1];

endmodule

// ===== hw/rtl/artificial_bulk_viscosity_core.sv =====
`timescale 1ns / 1ps

// Data passes through the bit-per-stage divider, cube root and square root pipelines.
// Throughput: one point per cycle; busy is never raised and the receiver cannot stall.
// Reset clears the pipeline valid bits and loads the coefficient register defaults.
module artificial_bulk_viscosity_core
    import abv_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  abv_in_t              in_data,
    output logic                 result_valid,
    output abv_out_t             result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int BW  = ((W > 32) ? W : 32) + 1;
    localparam int NW  = W + F;
    localparam int TW  = W - 1 + 2 * F;
    localparam int LRB = (TW + 2) / 3;

    typedef logic signed [W-1:0] word_t;
    typedef logic [W-1:0]        umag_t;
    typedef logic [2*W-1:0]      prod_t;

    localparam word_t WMAX_W = {1'b0, {(W-1){1'b1}}};
    localparam word_t WMIN_W = {1'b1, {(W-1){1'b0}}};
    localparam prod_t HALF   = prod_t'(1) << (W - 1);
    localparam logic signed [BW-1:0] O_MAX = BW'(33'sh07FFFFFFF);
    localparam logic signed [BW-1:0] O_MIN = BW'(33'sh180000000);

    // Side data carried through the pipelines.
    typedef struct packed {
        logic        ms_lt;
        logic        dv_neg;
        logic        dv_zero;
        word_t       vol;
        word_t       rho;
        word_t       c;
        logic [30:0] c_raw;
    } dside_t;

    typedef struct packed {
        logic        ms_lt;
        logic        rate_lt;
        word_t       rate;
        word_t       rho;
        word_t       c;
        logic [30:0] c_raw;
    } cside_t;

    typedef struct packed {
        logic        ms_lt;
        logic        rate_lt;
        word_t       q;
        word_t       m;
        logic [30:0] c_raw;
    } sside_t;

    // Arithmetic helpers on the word format.
    function automatic word_t clamp_big(input logic signed [BW-1:0] x);
        if (x > BW'(WMAX_W))
        begin
            return WMAX_W;
        end
        else if (x < BW'(WMIN_W))
        begin
            return WMIN_W;
        end
        return W'(x);
    endfunction

    function automatic word_t clamp_x(input logic signed [W:0] x);
        if (x > (W+1)'(WMAX_W))
        begin
            return WMAX_W;
        end
        else if (x < (W+1)'(WMIN_W))
        begin
            return WMIN_W;
        end
        return W'(x);
    endfunction

    function automatic umag_t mag(input word_t x);
        return x[W-1] ? umag_t'(-x) : umag_t'(x);
    endfunction

    function automatic word_t from_mag(input logic neg, input prod_t m);
        if (neg)
        begin
            if (m == '0)
            begin
                return '0;
            end
            else if (m > HALF)
            begin
                return WMIN_W;
            end
            return word_t'(umag_t'(0) - m[W-1:0]);
        end
        if (m >= HALF)
        begin
            return WMAX_W;
        end
        return word_t'(m[W-1:0]);
    endfunction

    function automatic word_t prod_sat(input logic neg, input prod_t p);
        return from_mag(neg, p >> F);
    endfunction

    function automatic word_t sadd(input word_t a, input word_t b);
        return clamp_x((W+1)'(a) + (W+1)'(b));
    endfunction

    function automatic word_t ssub(input word_t a, input word_t b);
        return clamp_x((W+1)'(a) - (W+1)'(b));
    endfunction

    // Configuration registers.
    logic [19:0] quad_reg;
    logic [19:0] lin_reg;
    logic [15:0] tiny_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quad_reg <= QUAD_RESET;
            lin_reg  <= LIN_RESET;
            tiny_reg <= TINY_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_QUAD: quad_reg <= pwdata[19:0];
                REG_LIN:  lin_reg  <= pwdata[19:0];
                REG_TINY: tiny_reg <= pwdata[15:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_QUAD: prdata = {12'd0, quad_reg};
            REG_LIN:  prdata = {12'd0, lin_reg};
            REG_TINY: prdata = {16'd0, tiny_reg};
            default:  prdata = 32'd0;
        endcase
    end

    // Negated epsilon, one bit wider than a word.
    logic signed [W:0] neg_eps;
    assign neg_eps = -$signed({{(W+1-16){1'b0}}, tiny_reg});

    // Input stage: saturate fields, test the stress and set up the division.
    word_t   in_ms;
    word_t   in_dv;
    word_t   in_dt;
    dside_t  in_side;

    always_comb
    begin
        in_ms           = clamp_big(BW'(in_data.mean_stress));
        in_dv           = clamp_big(BW'(in_data.volume_change));
        in_dt           = clamp_big(BW'($signed({1'b0, in_data.time_step})));
        in_side.vol     = clamp_big(BW'($signed({1'b0, in_data.point_volume})));
        in_side.rho     = clamp_big(BW'($signed({1'b0, in_data.point_density})));
        in_side.c       = clamp_big(BW'($signed({1'b0, in_data.sound_speed_in})));
        in_side.c_raw   = in_data.sound_speed_in;
        in_side.ms_lt   = ((W+1)'(in_ms) < neg_eps);
        in_side.dv_neg  = in_dv[W-1];
        in_side.dv_zero = (in_dv == '0);
    end

    logic          s0_vld_reg;
    logic [NW-1:0] s0_num_reg;
    logic [W-1:0]  s0_den_reg;
    dside_t        s0_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
        end
        else
        begin
            s0_vld_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        s0_num_reg  <= {mag(in_dv), {F{1'b0}}};
        s0_den_reg  <= umag_t'(in_dt);
        s0_side_reg <= in_side;
    end

    // Volume rate division.
    logic                    dv_vld;
    logic [NW-1:0]           dv_quo;
    logic [$bits(dside_t)-1:0] dv_side_bits;
    dside_t                  dv_side;

    abv_div #(
        .NW(NW),
        .DW(W),
        .SW($bits(dside_t))
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (s0_vld_reg),
        .in_num   (s0_num_reg),
        .in_den   (s0_den_reg),
        .in_side  (s0_side_reg),
        .out_vld  (dv_vld),
        .out_quo  (dv_quo),
        .out_side (dv_side_bits)
    );

    assign dv_side = dv_side_bits;

    // Rate stage: sign the quotient and test it against epsilon.
    word_t  r_rate;
    cside_t r_side;

    always_comb
    begin
        r_rate         = dv_side.dv_zero ? word_t'(0) : from_mag(dv_side.dv_neg, prod_t'(dv_quo));
        r_side.ms_lt   = dv_side.ms_lt;
        r_side.rate_lt = ((W+1)'(r_rate) < neg_eps);
        r_side.rate    = r_rate;
        r_side.rho     = dv_side.rho;
        r_side.c       = dv_side.c;
        r_side.c_raw   = dv_side.c_raw;
    end

    logic          r_vld_reg;
    logic [TW-1:0] r_t_reg;
    cside_t        r_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_vld_reg <= 1'b0;
        end
        else
        begin
            r_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        r_t_reg    <= {dv_side.vol[W-2:0], {(2*F){1'b0}}};
        r_side_reg <= r_side;
    end

    // Length scale from the cube root of the volume.
    logic                      cb_vld;
    logic [LRB-1:0]            cb_root;
    logic [$bits(cside_t)-1:0] cb_side_bits;
    cside_t                    cb_side;

    abv_cbrt #(
        .TW(TW),
        .SW($bits(cside_t))
    ) u_cbrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (r_vld_reg),
        .in_t     (r_t_reg),
        .in_side  (r_side_reg),
        .out_vld  (cb_vld),
        .out_root (cb_root),
        .out_side (cb_side_bits)
    );

    assign cb_side = cb_side_bits;

    word_t cb_len;
    assign cb_len = from_mag(1'b0, prod_t'(cb_root));

    // M1: quad*L, lin*c and rho*L.
    logic        m1_vld_reg;
    prod_t       m1_p1_reg;
    prod_t       m1_pb_reg;
    prod_t       m1_p2_reg;
    cside_t      m1_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_vld_reg <= 1'b0;
        end
        else
        begin
            m1_vld_reg <= cb_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        m1_p1_reg   <= prod_t'(quad_reg) * prod_t'(mag(cb_len));
        m1_pb_reg   <= prod_t'(lin_reg) * prod_t'(mag(cb_side.c));
        m1_p2_reg   <= prod_t'(mag(cb_side.rho)) * prod_t'(mag(cb_len));
        m1_side_reg <= cb_side;
    end

    // M2: multiply both length products by the rate.
    word_t m2_a1;
    word_t m2_r2;
    word_t m2_b;

    always_comb
    begin
        m2_a1 = prod_sat(1'b0, m1_p1_reg);
        m2_r2 = prod_sat(1'b0, m1_p2_reg);
        m2_b  = prod_sat(1'b0, m1_pb_reg);
    end

    logic   m2_vld_reg;
    prod_t  m2_pa_reg;
    logic   m2_pa_neg_reg;
    prod_t  m2_pq_reg;
    logic   m2_pq_neg_reg;
    word_t  m2_b_reg;
    cside_t m2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m2_vld_reg <= 1'b0;
        end
        else
        begin
            m2_vld_reg <= m1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m2_pa_reg     <= prod_t'(mag(m2_a1)) * prod_t'(mag(m1_side_reg.rate));
        m2_pa_neg_reg <= m2_a1[W-1] ^ m1_side_reg.rate[W-1];
        m2_pq_reg     <= prod_t'(mag(m2_r2)) * prod_t'(mag(m1_side_reg.rate));
        m2_pq_neg_reg <= m2_r2[W-1] ^ m1_side_reg.rate[W-1];
        m2_b_reg      <= m2_b;
        m2_side_reg   <= m1_side_reg;
    end

    // M3: form the difference terms.
    word_t m3_a;
    assign m3_a = prod_sat(m2_pa_neg_reg, m2_pa_reg);

    logic   m3_vld_reg;
    word_t  m3_p3_reg;
    word_t  m3_d_reg;
    word_t  m3_m_reg;
    cside_t m3_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m3_vld_reg <= 1'b0;
        end
        else
        begin
            m3_vld_reg <= m2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m3_p3_reg   <= prod_sat(m2_pq_neg_reg, m2_pq_reg);
        m3_d_reg    <= ssub(m3_a, m2_b_reg);
        m3_m_reg    <= ssub(m2_b_reg, m3_a);
        m3_side_reg <= m2_side_reg;
    end

    // M4: viscosity product and the two squares under the root.
    logic   m4_vld_reg;
    prod_t  m4_pq_reg;
    logic   m4_pq_neg_reg;
    prod_t  m4_mm_reg;
    prod_t  m4_cc_reg;
    word_t  m4_m_reg;
    cside_t m4_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m4_vld_reg <= 1'b0;
        end
        else
        begin
            m4_vld_reg <= m3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m4_pq_reg     <= prod_t'(mag(m3_p3_reg)) * prod_t'(mag(m3_d_reg));
        m4_pq_neg_reg <= m3_p3_reg[W-1] ^ m3_d_reg[W-1];
        m4_mm_reg     <= prod_t'(mag(m3_m_reg)) * prod_t'(mag(m3_m_reg));
        m4_cc_reg     <= prod_t'(mag(m3_side_reg.c)) * prod_t'(mag(m3_side_reg.c));
        m4_m_reg      <= m3_m_reg;
        m4_side_reg   <= m3_side_reg;
    end

    // M5: saturate the viscosity and sum the squares.
    sside_t m5_side;

    always_comb
    begin
        m5_side.ms_lt   = m4_side_reg.ms_lt;
        m5_side.rate_lt = m4_side_reg.rate_lt;
        m5_side.q       = prod_sat(m4_pq_neg_reg, m4_pq_reg);
        m5_side.m       = m4_m_reg;
        m5_side.c_raw   = m4_side_reg.c_raw;
    end

    logic   m5_vld_reg;
    prod_t  m5_t_reg;
    sside_t m5_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m5_vld_reg <= 1'b0;
        end
        else
        begin
            m5_vld_reg <= m4_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        m5_t_reg    <= m4_mm_reg + m4_cc_reg;
        m5_side_reg <= m5_side;
    end

    // Square root for the raised sound speed.
    logic                      sq_vld;
    logic [W-1:0]              sq_root;
    logic [$bits(sside_t)-1:0] sq_side_bits;
    sside_t                    sq_side;

    abv_sqrt #(
        .RB(W),
        .SW($bits(sside_t))
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (m5_vld_reg),
        .in_t     (m5_t_reg),
        .in_side  (m5_side_reg),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_side (sq_side_bits)
    );

    assign sq_side = sq_side_bits;

    // Output stage: final sum, clamp to the port ranges, select by the flag.
    word_t               f_s;
    logic signed [BW-1:0] f_s_big;
    logic signed [BW-1:0] f_q_big;
    logic [30:0]         f_s31;
    logic [31:0]         f_q32;
    abv_out_t            f_out;

    always_comb
    begin
        f_s     = sadd(sq_side.m, from_mag(1'b0, prod_t'(sq_root)));
        f_s_big = BW'(f_s);
        f_q_big = BW'(sq_side.q);
        if (f_s_big < 0)
        begin
            f_s31 = '0;
        end
        else if (f_s_big > O_MAX)
        begin
            f_s31 = '1;
        end
        else
        begin
            f_s31 = f_s_big[30:0];
        end
        if (f_q_big > O_MAX)
        begin
            f_q32 = O_MAX[31:0];
        end
        else if (f_q_big < O_MIN)
        begin
            f_q32 = O_MIN[31:0];
        end
        else
        begin
            f_q32 = f_q_big[31:0];
        end
        f_out.compressing     = sq_side.ms_lt && sq_side.rate_lt;
        f_out.bulk_viscosity  = f_out.compressing ? $signed(f_q32) : 32'sd0;
        f_out.sound_speed_out = f_out.compressing ? f_s31 : sq_side.c_raw;
    end

    logic     out_vld_reg;
    abv_out_t out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= sq_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= f_out;
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import abv_pkg::*;

    localparam longint WMAX = 64'sd2147483647;
    localparam longint WMIN = -64'sd2147483648;
    localparam logic [1:0] REG_UNMAPPED = 2'd3;
    localparam int DRAIN_CYCLES = 130;

    // One row of the directed stimulus table.
    typedef struct {
        abv_in_t  point;
        bit       typed;
        abv_out_t want;
    } point_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    abv_in_t              in_data;
    logic                 result_valid;
    abv_out_t             result;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    // Register copies used by the viscosity predictor.
    longint quad_now;
    longint lin_now;
    longint tiny_now;

    abv_out_t   pending_beats[$];
    int         mismatch_count;
    int         max_gap;
    point_row_t point_table[$];

    artificial_bulk_viscosity_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .in_data      (in_data),
        .result_valid (result_valid),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Clock: 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Saturate to the signed 32-bit word.
    function automatic longint clamp_word(longint x);
        if (x > WMAX)
        begin
            return WMAX;
        end
        if (x < WMIN)
        begin
            return WMIN;
        end
        return x;
    endfunction

    function automatic logic [127:0] magnitude(longint x);
        return (x < 0) ? 128'(-x) : 128'(x);
    endfunction

    // Apply a sign to a magnitude and saturate.
    function automatic longint signed_from_mag(bit neg, logic [127:0] m);
        if (neg)
        begin
            if (m == 0)
            begin
                return 0;
            end
            return (m > 128'd2147483648) ? WMIN : -longint'(m[63:0]);
        end
        return (m > 128'(WMAX)) ? WMAX : longint'(m[63:0]);
    endfunction

    // Fixed-point product, magnitude truncated, then saturated.
    function automatic longint fx_mul(longint a, longint b);
        logic [127:0] p;
        p = (magnitude(a) * magnitude(b)) >> 16;
        return signed_from_mag((a < 0) != (b < 0), p);
    endfunction

    // Floor of the cube root of vol * 2^32.
    function automatic longint cube_root_len(longint vol);
        logic [127:0] t;
        logic [127:0] r;
        logic [127:0] c;
        t = 128'(vol) << 32;
        r = 0;
        for (int i = 31; i >= 0; i--)
        begin
            c = r | (128'd1 << i);
            if (c * c * c <= t)
            begin
                r = c;
            end
        end
        return longint'(r[63:0]);
    endfunction

    // Floor of the square root of a wide value.
    function automatic logic [127:0] wide_sqrt(logic [127:0] t);
        logic [127:0] r;
        logic [127:0] c;
        r = 0;
        for (int i = 63; i >= 0; i--)
        begin
            c = r | (128'd1 << i);
            if (c * c <= t)
            begin
                r = c;
            end
        end
        return r;
    endfunction

    // Predicted viscosity beat for one material point.
    function automatic abv_out_t viscosity_of(abv_in_t p);
        abv_out_t     o;
        longint       ms;
        longint       dv;
        longint       dt;
        longint       rho;
        longint       c;
        longint       rate;
        longint       len;
        longint       a;
        longint       b;
        longint       q;
        longint       m;
        longint       s;
        logic [127:0] root;
        ms  = longint'($signed(p.mean_stress));
        dv  = longint'($signed(p.volume_change));
        dt  = longint'(p.time_step);
        rho = longint'(p.point_density);
        c   = longint'(p.sound_speed_in);
        o.bulk_viscosity  = '0;
        o.sound_speed_out = p.sound_speed_in;
        o.compressing     = 1'b0;
        if (!(ms < -tiny_now))
        begin
            return o;
        end
        if (dt == 0)
        begin
            rate = (dv < 0) ? WMIN : ((dv > 0) ? WMAX : 0);
        end
        else
        begin
            rate = signed_from_mag(dv < 0, (magnitude(dv) << 16) / 128'(dt));
        end
        if (!(rate < -tiny_now))
        begin
            return o;
        end
        len  = clamp_word(cube_root_len(longint'(p.point_volume)));
        a    = fx_mul(fx_mul(quad_now, len), rate);
        b    = fx_mul(lin_now, c);
        q    = fx_mul(fx_mul(fx_mul(rho, len), rate), clamp_word(a - b));
        m    = clamp_word(b - a);
        root = wide_sqrt(magnitude(m) * magnitude(m) + magnitude(c) * magnitude(c));
        if (root > 128'(WMAX))
        begin
            root = 128'(WMAX);
        end
        s = clamp_word(m + longint'(root[63:0]));
        if (s < 0)
        begin
            s = 0;
        end
        o.bulk_viscosity  = q[31:0];
        o.sound_speed_out = s[30:0];
        o.compressing     = 1'b1;
        return o;
    endfunction

    function automatic void note_mismatch(string what, longint want, longint got);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("Mismatch in %s: expected %0d, got %0d", what, want, got);
        end
    endfunction

    // Check every result beat against the oldest expectation.
    always @(posedge clk)
    begin
        abv_out_t want;
        if (rst_n && result_valid)
        begin
            if (pending_beats.size() == 0)
            begin
                note_mismatch("unexpected result beat", longint'(0), longint'(1));
            end
            else
            begin
                want = pending_beats.pop_front();
                if (result.bulk_viscosity !== want.bulk_viscosity)
                begin
                    note_mismatch("bulk_viscosity", longint'($signed(want.bulk_viscosity)),
                                  longint'($signed(result.bulk_viscosity)));
                end
                if (result.sound_speed_out !== want.sound_speed_out)
                begin
                    note_mismatch("sound_speed_out", longint'(want.sound_speed_out),
                                  longint'(result.sound_speed_out));
                end
                if (result.compressing !== want.compressing)
                begin
                    note_mismatch("compressing", longint'(want.compressing),
                                  longint'(result.compressing));
                end
            end
        end
    end

    // Register write over the configuration port, then a read back unless the index is unmapped.
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        logic [31:0] seen;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_QUAD: quad_now = longint'(value[19:0]);
            REG_LIN:  lin_now  = longint'(value[19:0]);
            REG_TINY: tiny_now = longint'(value[15:0]);
            default: ;
        endcase
        if (idx == REG_UNMAPPED)
        begin
            return;
        end
        // Read back the register just written.
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        seen = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (seen !== ((idx == REG_TINY) ? (value & 32'hFFFF) : (value & 32'hFFFFF)))
        begin
            note_mismatch("register read back", longint'(value), longint'(seen));
        end
    endtask

    // Send one point beat after a random gap; record what it must produce.
    task automatic send_point(abv_in_t p, bit typed, abv_out_t want);
        int gap;
        gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        in_data <= p;
        do @(posedge clk); while (busy);
        pending_beats.insert(pending_beats.size(), typed ? want : viscosity_of(p));
    endtask

    // Let the pipeline drain before touching the registers.
    task automatic wait_idle();
        start <= 1'b0;
        while (pending_beats.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Random value whose magnitude spans a random number of bits.
    function automatic logic [31:0] scaled_rand();
        int w;
        w = $urandom_range(0, 32);
        return (w == 32) ? $urandom : ($urandom & ((32'd1 << w) - 1));
    endfunction

    function automatic abv_in_t random_point();
        abv_in_t p;
        logic [31:0] r;
        p.time_step      = 31'(scaled_rand());
        p.point_volume   = 31'(scaled_rand());
        p.point_density  = 31'(scaled_rand());
        p.sound_speed_in = 31'(scaled_rand());
        if ($urandom_range(0, 9) < 7)
        begin
            // Point with negative stress and volume change and random content.
            r = scaled_rand();
            p.mean_stress   = -$signed({1'b0, r[30:0]}) - 2;
            r = scaled_rand();
            p.volume_change = -$signed({1'b0, r[30:0]}) - 1;
            if ($urandom_range(0, 19) == 0)
            begin
                p.time_step = '0;
            end
        end
        else
        begin
            p.mean_stress   = $urandom;
            p.volume_change = $urandom;
        end
        return p;
    endfunction

    function automatic abv_in_t make_point(logic [31:0] ms, logic [31:0] dv,
                                           logic [30:0] dt, logic [30:0] vol,
                                           logic [30:0] rho, logic [30:0] c);
        abv_in_t p;
        p.mean_stress    = ms;
        p.volume_change  = dv;
        p.time_step      = dt;
        p.point_volume   = vol;
        p.point_density  = rho;
        p.sound_speed_in = c;
        return p;
    endfunction

    function automatic void add_row(abv_in_t p, bit typed);
        point_row_t row;
        row.point = p;
        row.typed = typed;
        row.want.bulk_viscosity  = '0;
        row.want.sound_speed_out = p.sound_speed_in;
        row.want.compressing     = 1'b0;
        point_table.insert(point_table.size(), row);
    endfunction

    // Run the random part under one register setting.
    task automatic random_phase(int count, logic [19:0] quad, logic [19:0] lin,
                                logic [15:0] tiny);
        abv_out_t none;
        none = '0;
        wait_idle();
        write_reg(REG_QUAD, 32'(quad));
        write_reg(REG_LIN, 32'(lin));
        write_reg(REG_TINY, 32'(tiny));
        for (int i = 0; i < count; i++)
        begin
            if (i % 50 == 0)
            begin
                max_gap = ($urandom_range(0, 2) == 0) ? 0 : 10;
            end
            send_point(random_point(), 1'b0, none);
        end
    endtask

    // Main sequence.
    initial
    begin
        abv_out_t none;
        none           = '0;
        rst_n          = 1'b0;
        start          = 1'b0;
        in_data        = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        mismatch_count = 0;
        max_gap        = 10;
        quad_now       = longint'(QUAD_RESET);
        lin_now        = longint'(LIN_RESET);
        tiny_now       = longint'(TINY_RESET);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table; pass-through rows carry their typed result.
        add_row(make_point(32'sd65536, -32'sd65536, 31'd65536, 31'd65536, 31'd65536,
                           31'd65536), 1'b1);
        add_row(make_point(-32'sd1, -32'sd65536, 31'd65536, 31'd65536, 31'd65536,
                           31'd12345), 1'b1);
        add_row(make_point(-32'sd2, -32'sd65536, 31'd65536, 31'd65536, 31'd65536,
                           31'd65536), 1'b0);
        add_row(make_point(32'h7FFFFFFF, 32'h80000000, 31'h7FFFFFFF, 31'h7FFFFFFF,
                           31'h7FFFFFFF, 31'h7FFFFFFF), 1'b1);
        add_row(make_point(32'h80000000, 32'h80000000, 31'd1, 31'h7FFFFFFF,
                           31'h7FFFFFFF, 31'h7FFFFFFF), 1'b0);
        add_row(make_point(32'h80000000, 32'h80000000, 31'h7FFFFFFF, 31'h7FFFFFFF,
                           31'h7FFFFFFF, 31'h7FFFFFFF), 1'b0);
        add_row(make_point(-32'sd65536, -32'sd1, 31'd0, 31'd65536, 31'd65536,
                           31'd65536), 1'b0);
        add_row(make_point(-32'sd65536, 32'sd1, 31'd0, 31'd65536, 31'd65536,
                           31'd777), 1'b1);
        add_row(make_point(-32'sd65536, 32'sd0, 31'd0, 31'd65536, 31'd65536,
                           31'd999), 1'b1);
        add_row(make_point(-32'sd65536, 32'sd0, 31'd1, 31'd65536, 31'd65536,
                           31'd5), 1'b1);
        add_row(make_point(-32'sd65536, -32'sd1, 31'd65536, 31'd65536, 31'd65536,
                           31'd31), 1'b1);
        add_row(make_point(-32'sd65536, -32'sd2, 31'd65536, 31'd65536, 31'd65536,
                           31'd65536), 1'b0);
        add_row(make_point(-32'sd65536, -32'sd65536, 31'd65536, 31'd0, 31'd65536,
                           31'd65536), 1'b0);
        add_row(make_point(-32'sd65536, -32'sd65536, 31'd65536, 31'd65536, 31'd0,
                           31'd0), 1'b0);
        add_row(make_point(-32'sd65536, -32'sd65536, 31'd3, 31'h7FFFFFFF, 31'd65536,
                           31'd0), 1'b0);
        add_row(make_point(-32'sd100, -32'sd100, 31'd1, 31'd1, 31'd1, 31'd1), 1'b0);
        add_row(make_point(32'sd0, 32'sd0, 31'd0, 31'd0, 31'd0, 31'd0), 1'b1);
        foreach (point_table[i])
        begin
            send_point(point_table[i].point, point_table[i].typed, point_table[i].want);
        end

        // Writes to an unmapped index must leave the registers unchanged.
        wait_idle();
        write_reg(REG_UNMAPPED, 32'hFFFFFFFF);
        send_point(make_point(-32'sd2, -32'sd65536, 31'd65536, 31'd65536, 31'd65536,
                              31'd65536), 1'b0, none);

        // Random phases over several register settings, extremes included.
        random_phase(200, QUAD_RESET, LIN_RESET, TINY_RESET);
        random_phase(150, 20'hFFFFF, 20'hFFFFF, 16'hFFFF);
        random_phase(150, 20'h0, 20'h0, 16'h0);
        random_phase(150, 20'($urandom), 20'($urandom), 16'($urandom));
        random_phase(150, 20'($urandom_range(0, 300000)), 20'($urandom_range(0, 20000)),
                     16'($urandom_range(0, 64)));

        // Drain and finish.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_beats.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    // Timeout guard.
    initial
    begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
